// ===== src/mhp_pkg.sv =====
// Shared types, constants and the probe target table for the hop probe controller.
`default_nettype none
package mhp_pkg;

  localparam int TARGET_LEN = 17;
  localparam int MAX_BURST  = 16;

  localparam logic [1:0] KIND_PROBE   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  localparam logic CFG_DEST    = 1'b0;
  localparam logic CFG_MAXADDR = 1'b1;

  typedef struct packed {
    logic [31:0] addr;
    logic [6:0]  hit;
    logic [23:0] rtt_min;
    logic [23:0] rtt_max;
    logic [30:0] sum;
    logic [54:0] sumsq;
  } entry_t;

  function automatic logic [6:0] probe_target(input logic [4:0] i);
    logic [6:0] t;
    case (i)
      5'd0:    t = 7'd6;
      5'd1:    t = 7'd6;
      5'd2:    t = 7'd11;
      5'd3:    t = 7'd16;
      5'd4:    t = 7'd21;
      5'd5:    t = 7'd27;
      5'd6:    t = 7'd33;
      5'd7:    t = 7'd38;
      5'd8:    t = 7'd44;
      5'd9:    t = 7'd51;
      5'd10:   t = 7'd57;
      5'd11:   t = 7'd63;
      5'd12:   t = 7'd70;
      5'd13:   t = 7'd76;
      5'd14:   t = 7'd83;
      5'd15:   t = 7'd90;
      5'd16:   t = 7'd96;
      default: t = 7'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== src/multipath_hop_probe_controller_unit.sv =====
// Top level: hop probe controller with per-address RTT statistics memory.
// One input transaction is taken at a time. A start transaction emits probe requests; a reply
// searches the stored addresses. The closing summary scans the memory once per address reported
// and uses the shared 55-bit serial divider for the mean and the mean square.
// Results leave through a single output register; a new input is taken while the last one waits.
`default_nettype none
module multipath_hop_probe_controller_unit #(
  parameter int ADDR_CAPACITY = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // hop_ttl, reply_address, reply_flow_id, reply_rtt_us, pad
  input  wire  [71:0]  s_tdata,
  // opcode, reply_is_star
  input  wire  [1:0]   s_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  // destination, ttl, flow_id, address, reply_count, rtt_min, rtt_mean, rtt_max,
  // rtt_variance, probes_total, pad
  output logic [215:0] m_tdata,
  // kind
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  input  wire          cfg_we,
  input  wire          cfg_index,
  input  wire  [31:0]  cfg_data
);
  import mhp_pkg::*;

  localparam int IW = (ADDR_CAPACITY > 1) ? $clog2(ADDR_CAPACITY) : 1;
  localparam int CW = $clog2(ADDR_CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SCMP, S_UPD, S_DECIDE, S_PROBE, S_EMPTY,
    S_SRD, S_SCHK, S_BRD, S_BWAIT, S_DIV1, S_DIV2, S_SQ, S_SOUT
  } state_t;

  state_t      state;
  logic [31:0] dest_address;
  logic [3:0]  max_addresses;
  logic        active;
  logic [7:0]  hop_ttl;
  logic [6:0]  sent_cnt;
  logic [6:0]  probes_pending;
  logic [CW-1:0] dc;
  logic [CW-1:0] idx;
  logic [IW-1:0] best;
  logic        found;
  logic [31:0] best_addr;
  logic [31:0] prev_addr;
  logic        prev_valid;
  logic [4:0]  k;
  logic [4:0]  cnt;
  logic [31:0] r_addr;
  logic [23:0] r_rtt;
  logic [47:0] r_sq;
  entry_t      e;
  logic [6:0]  e_n;
  logic [23:0] mean;
  logic [54:0] msq;
  logic [47:0] sq;

  logic [1:0]  o_kind;
  logic [7:0]  o_ttl;
  logic [31:0] o_dest;
  logic [6:0]  o_flow;
  logic [31:0] o_addr;
  logic [6:0]  o_count;
  logic [23:0] o_min;
  logic [23:0] o_mean;
  logic [23:0] o_max;
  logic [47:0] o_var;
  logic [6:0]  o_total;

  logic        in_acc;
  logic        out_free;
  logic        emit;
  logic [6:0]  dc_w;
  logic [6:0]  tgt;
  logic [6:0]  need;
  logic [4:0]  burst;
  logic [4:0]  nsum;
  logic        cand;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  entry_t      mem_wdata;
  entry_t      rd;
  logic        div_start;
  logic [54:0] div_dividend;
  logic [6:0]  div_divisor;
  logic        div_done;
  logic [54:0] div_q;
  logic [54:0] var_full;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign emit     = out_free && (state == S_PROBE || state == S_EMPTY || state == S_SOUT);

  assign dc_w  = 7'(dc);
  assign tgt   = probe_target(dc_w[4:0]);
  assign need  = (dc_w >= {3'b0, max_addresses} || dc_w >= 7'(TARGET_LEN)) ? 7'd0 :
                 (tgt > sent_cnt) ? 7'(tgt - sent_cnt) : 7'd0;
  assign burst = (need > 7'(MAX_BURST)) ? 5'(MAX_BURST) : need[4:0];
  assign nsum  = (dc_w > 7'(MAX_BURST)) ? 5'(MAX_BURST) : dc_w[4:0];
  assign cand  = (!prev_valid || rd.addr > prev_addr) && (!found || rd.addr < best_addr);

  assign var_full = (msq > {7'b0, sq}) ? 55'(msq - {7'b0, sq}) : 55'd0;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[IW-1:0];
    mem_wdata = rd;
    if (state == S_SRCH && idx == dc && dc_w < 7'(ADDR_CAPACITY)) begin
      mem_we          = 1'b1;
      mem_waddr       = dc[IW-1:0];
      mem_wdata.addr  = r_addr;
      mem_wdata.hit   = 7'd1;
      mem_wdata.rtt_min = r_rtt;
      mem_wdata.rtt_max = r_rtt;
      mem_wdata.sum   = 31'(r_rtt);
      mem_wdata.sumsq = 55'(r_sq);
    end else if (state == S_UPD) begin
      mem_we          = 1'b1;
      mem_wdata.hit   = 7'(rd.hit + 7'd1);
      mem_wdata.rtt_min = (r_rtt < rd.rtt_min) ? r_rtt : rd.rtt_min;
      mem_wdata.rtt_max = (r_rtt > rd.rtt_max) ? r_rtt : rd.rtt_max;
      mem_wdata.sum   = 31'(rd.sum + 31'(r_rtt));
      mem_wdata.sumsq = 55'(rd.sumsq + 55'(r_sq));
    end
  end

  assign mem_raddr = (state == S_BRD || state == S_BWAIT) ? best : idx[IW-1:0];

  mhp_stats_mem #(.DEPTH(ADDR_CAPACITY), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  assign div_start    = (state == S_BWAIT) || (state == S_DIV1 && div_done);
  assign div_dividend = (state == S_BWAIT) ? 55'(rd.sum) : e.sumsq;
  assign div_divisor  = (state == S_BWAIT) ? ((rd.hit == 7'd0) ? 7'd1 : rd.hit) : e_n;

  mhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_address  <= '0;
      max_addresses <= 4'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEST:    dest_address  <= cfg_data;
        CFG_MAXADDR: max_addresses <= cfg_data[3:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      active         <= 1'b0;
      hop_ttl        <= '0;
      sent_cnt       <= '0;
      probes_pending <= '0;
      dc             <= '0;
      m_tvalid       <= 1'b0;
      m_tlast        <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            r_addr <= s_tdata[39:8];
            r_rtt  <= s_tdata[70:47];
            r_sq   <= s_tdata[70:47] * s_tdata[70:47];
            idx    <= '0;
            if (s_tuser[0] == OP_START) begin
              hop_ttl        <= s_tdata[7:0];
              active         <= 1'b1;
              sent_cnt       <= '0;
              probes_pending <= '0;
              dc             <= '0;
              state          <= S_DECIDE;
            end else if (active && probes_pending != 7'd0) begin
              probes_pending <= 7'(probes_pending - 7'd1);
              state          <= s_tuser[1] ? S_DECIDE : S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (idx == dc) begin
            if (dc_w < 7'(ADDR_CAPACITY)) begin
              dc <= CW'(dc + 1'b1);
            end
            state <= S_DECIDE;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (rd.addr == r_addr) begin
            state <= S_UPD;
          end else begin
            idx   <= CW'(idx + 1'b1);
            state <= S_SRCH;
          end
        end
        S_UPD: state <= S_DECIDE;
        S_DECIDE: begin
          k          <= '0;
          idx        <= '0;
          found      <= 1'b0;
          prev_valid <= 1'b0;
          cnt        <= burst;
          if (need == 7'd0 && probes_pending == 7'd0) begin
            state <= (dc == '0) ? S_EMPTY : S_SRD;
          end else if (need != 7'd0) begin
            state <= S_PROBE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PROBE: begin
          if (out_free) begin
            m_tlast  <= (k == 5'(cnt - 5'd1));
            o_kind   <= KIND_PROBE;
            o_dest   <= dest_address;
            o_ttl    <= hop_ttl;
            o_flow   <= 7'(sent_cnt + 7'(k));
            o_addr   <= '0;
            o_count  <= '0;
            o_min    <= '0;
            o_mean   <= '0;
            o_max    <= '0;
            o_var    <= '0;
            o_total  <= '0;
            k        <= 5'(k + 5'd1);
            if (k == 5'(cnt - 5'd1)) begin
              sent_cnt       <= 7'(sent_cnt + 7'(cnt));
              probes_pending <= 7'(probes_pending + 7'(cnt));
              state          <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            m_tlast  <= 1'b1;
            o_kind   <= KIND_EMPTY;
            o_dest   <= dest_address;
            o_ttl    <= hop_ttl;
            o_flow   <= '0;
            o_addr   <= '0;
            o_count  <= '0;
            o_min    <= '0;
            o_mean   <= '0;
            o_max    <= '0;
            o_var    <= '0;
            o_total  <= sent_cnt;
            active   <= 1'b0;
            state    <= S_IDLE;
          end
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (cand) begin
            found     <= 1'b1;
            best      <= idx[IW-1:0];
            best_addr <= rd.addr;
          end
          idx   <= CW'(idx + 1'b1);
          state <= (CW'(idx + 1'b1) == dc) ? S_BRD : S_SRD;
        end
        S_BRD: state <= S_BWAIT;
        S_BWAIT: begin
          e     <= rd;
          e_n   <= (rd.hit == 7'd0) ? 7'd1 : rd.hit;
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (div_done) begin
            mean  <= div_q[23:0];
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            msq   <= div_q;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq    <= mean * mean;
          state <= S_SOUT;
        end
        S_SOUT: begin
          if (out_free) begin
            m_tlast    <= (k == 5'(nsum - 5'd1));
            o_kind     <= KIND_SUMMARY;
            o_dest     <= dest_address;
            o_ttl      <= hop_ttl;
            o_flow     <= '0;
            o_addr     <= e.addr;
            o_count    <= e.hit;
            o_min      <= e.rtt_min;
            o_mean     <= mean;
            o_max      <= e.rtt_max;
            o_var      <= var_full[47:0];
            o_total    <= sent_cnt;
            prev_addr  <= e.addr;
            prev_valid <= 1'b1;
            found      <= 1'b0;
            idx        <= '0;
            k          <= 5'(k + 5'd1);
            if (k == 5'(nsum - 5'd1)) begin
              active <= 1'b0;
              state  <= S_IDLE;
            end else begin
              state <= S_SRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tuser = o_kind;
  assign m_tdata = {3'b0, o_total, o_var, o_max, o_mean, o_min, o_count, o_addr,
                    o_flow, o_ttl, o_dest};

  a_pending_le_sent: assert property (@(posedge clk) disable iff (rst)
    probes_pending <= sent_cnt) else $error("more probes pending than sent");
  a_dc_cap: assert property (@(posedge clk) disable iff (rst)
    dc_w <= 7'(ADDR_CAPACITY)) else $error("distinct count beyond capacity");
  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> (cnt != 5'd0 && k < cnt)) else $error("probe burst overrun");
  a_sum_found: assert property (@(posedge clk) disable iff (rst)
    state == S_BRD |-> found) else $error("summary scan found no address");

endmodule
`default_nettype wire

// ===== src/mhp_stats_mem.sv =====
// Per-address statistics memory: one write port, one registered read port.
`default_nettype none
module mhp_stats_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire                  clk,
  input  wire                  we,
  input  wire  [AW-1:0]        waddr,
  input  mhp_pkg::entry_t      wdata,
  input  wire  [AW-1:0]        raddr,
  output mhp_pkg::entry_t      rdata
);
  import mhp_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/mhp_div.sv =====
// Bit-serial restoring divider, 55-bit dividend by 7-bit divisor.
`default_nettype none
module mhp_div (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [54:0] dividend,
  input  wire  [6:0]  divisor,
  output logic        done,
  output logic [54:0] quotient
);
  import mhp_pkg::*;

  logic        busy;
  logic [5:0]  step;
  logic [6:0]  rem;
  logic [6:0]  dvs;
  logic [7:0]  trial;

  assign trial = {rem, quotient[54]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= 7'(trial - {1'b0, dvs});
          quotient <= {quotient[53:0], 1'b1};
        end else begin
          rem      <= trial[6:0];
          quotient <= {quotient[53:0], 1'b0};
        end
        step <= 6'(step + 6'd1);
        if (step == 6'd54) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= 6'd54) else $error("divider step overrun");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider failed to start");

endmodule
`default_nettype wire
